FILE: design/assert_macros.svh
// Assertion helpers for the heatmap design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/khle_pkg.sv
// ----------------------------------------------------------------------------
// khle_pkg
// Shared types and constants of the key heatmap LED effect.
// ----------------------------------------------------------------------------
package khle_pkg;
  localparam logic [1:0] CMD_PRESS = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_COORD = 2'd2;

  localparam logic [2:0] REG_PERIOD = 3'd0;
  localparam logic [2:0] REG_SPREAD = 3'd1;
  localparam logic [2:0] REG_AREA   = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_SLIM   = 3'd4;
  localparam logic [2:0] REG_BRIGHT = 3'd5;

  typedef struct packed {
    logic [15:0] decay_period_ms;
    logic [15:0] spread_radius;
    logic [7:0]  nb_cap;
    logic [7:0]  press_gain;
    logic        slim_mode;
    logic [7:0]  base_brightness;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRESS_RD, ST_PRESS_WR, ST_NB_RD, ST_NB_WAIT, ST_NB_SQRT, ST_NB_MUL,
    ST_NB_DIV, ST_NB_WR, ST_DIV_FR, ST_FR_RD, ST_FR_WAIT, ST_FR_MUL, ST_FR_OUT
  } state_t;

  // Heat-table memory request
  typedef struct packed {
    logic       we;
    logic [5:0] addr;
    logic [7:0] wdata;
  } mem_req_t;
endpackage

FILE: design/khle_if.sv
// ----------------------------------------------------------------------------
// khle_in_if / khle_out_if
// Valid/ready channels carrying input requests and LED results.
// ----------------------------------------------------------------------------
interface khle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] led_index;
  logic [15:0] elapsed_ms;
  logic [6:0] frame_leds;
  logic [7:0] coord_x;
  logic [7:0] coord_y;
  logic       coord_valid;
  modport source (output valid, cmd, led_index, elapsed_ms, frame_leds, coord_x, coord_y,
                  coord_valid, input ready);
  modport sink (input valid, cmd, led_index, elapsed_ms, frame_leds, coord_x, coord_y,
                coord_valid, output ready);
endinterface

interface khle_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_led;
  logic [7:0] heat;
  logic [7:0] hue;
  logic [7:0] brightness;
  logic       lit;
  logic       last;
  modport source (output valid, out_led, heat, hue, brightness, lit, last, input ready);
  modport sink (input valid, out_led, heat, hue, brightness, lit, last, output ready);
endinterface

FILE: design/key_heatmap_led_effect.sv
// Coordinate writes are stored from idle. A press on an unplaced LED ends after its reads; else it
// heats it and (not slim, radius set) roots each placed neighbor's distance, dividing if in range.
// Frame tick: a decay divide, then per LED a read, decay write, color multiply and stallable output.
// One request at a time; the output register holds a result while the next is computed.
// Synchronous reset restores the register defaults and marks every LED cold and unplaced.
// ----------------------------------------------------------------------------
// key_heatmap_led_effect
// Typing heatmap: heat per LED, neighbor spreading, decay and color output.
// ----------------------------------------------------------------------------
module key_heatmap_led_effect #(
  parameter int LED_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  khle_in_if.sink     in_ch,
  khle_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import khle_pkg::*;
  cfg_t cfg;

  khle_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
                    .pready, .cfg);
  khle_core #(.LED_COUNT(LED_COUNT)) u_core (.clk, .rst, .cfg, .in_ch, .out_ch);
endmodule

FILE: design/khle_divider.sv
// ----------------------------------------------------------------------------
// khle_divider
// Restoring divider, one quotient bit per cycle, 24-bit by 16-bit.
// ----------------------------------------------------------------------------
module khle_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [23:0] quotient
);
  logic [23:0] quo;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [15:0] dsr;
  logic [16:0] trial;

  assign trial = {rem[15:0], quo[23]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/khle_sqrt.sv
// ----------------------------------------------------------------------------
// khle_sqrt
// Floor square root of a 17-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module khle_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] value,
  output logic        done,
  output logic [8:0]  root
);
  logic [16:0] v;
  logic [16:0] res;
  logic [16:0] bitv;
  logic        busy;

  assign root = res[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= value;
        res  <= '0;
        bitv <= 17'h10000;
      end else if (busy) begin
        if (v >= res + bitv) begin
          v   <= v - (res + bitv);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 17'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/khle_regs.sv
// ----------------------------------------------------------------------------
// khle_regs
// APB register file holding the effect settings.
// ----------------------------------------------------------------------------
module khle_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output khle_pkg::cfg_t cfg
);
  import khle_pkg::*;
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_period_ms <= 16'd25;
      cfg.spread_radius   <= 16'd40;
      cfg.nb_cap          <= 8'd16;
      cfg.press_gain      <= 8'd32;
      cfg.slim_mode       <= 1'b0;
      cfg.base_brightness <= 8'd255;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_PERIOD: cfg.decay_period_ms <= pwdata[15:0];
        REG_SPREAD: cfg.spread_radius   <= pwdata[15:0];
        REG_AREA:   cfg.nb_cap          <= pwdata[7:0];
        REG_STEP:   cfg.press_gain      <= pwdata[7:0];
        REG_SLIM:   cfg.slim_mode       <= pwdata[0];
        REG_BRIGHT: cfg.base_brightness <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: prdata = {16'd0, cfg.decay_period_ms};
      REG_SPREAD: prdata = {16'd0, cfg.spread_radius};
      REG_AREA:   prdata = {24'd0, cfg.nb_cap};
      REG_STEP:   prdata = {24'd0, cfg.press_gain};
      REG_SLIM:   prdata = {31'd0, cfg.slim_mode};
      REG_BRIGHT: prdata = {24'd0, cfg.base_brightness};
      default:    prdata = '0;
    endcase
  end
endmodule

FILE: design/khle_core.sv
// ----------------------------------------------------------------------------
// khle_core
// Sequencer over the heat and coordinate memories.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module khle_core #(
  parameter int LED_COUNT = 64
) (
  input  logic clk,
  input  logic rst,
  input  khle_pkg::cfg_t cfg,
  khle_in_if.sink  in_ch,
  khle_out_if.source out_ch
);
  import khle_pkg::*;

  localparam logic [6:0] CNT = 7'(LED_COUNT);

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // Memories: heat and coordinates, with registered reads.
  logic [7:0]  heat_mem  [LED_COUNT];
  logic [16:0] coord_mem [LED_COUNT];
  logic [LED_COUNT-1:0] heat_ok;   // entry written since reset
  logic [LED_COUNT-1:0] coord_ok;

  mem_req_t    hreq;
  logic [5:0]  craddr;
  logic [7:0]  hrd_raw;
  logic [16:0] crd_raw;
  logic        hrd_ok, crd_ok;
  logic [7:0]  hrd;
  logic [16:0] crd;
  logic        cwe;

  always_ff @(posedge clk) begin
    if (hreq.we) heat_mem[hreq.addr] <= hreq.wdata;
    hrd_raw <= heat_mem[hreq.addr];
    if (cwe) coord_mem[in_ch.led_index] <= {in_ch.coord_valid, in_ch.coord_y, in_ch.coord_x};
    crd_raw <= coord_mem[craddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_ok  <= '0;
      coord_ok <= '0;
      hrd_ok   <= 1'b0;
      crd_ok   <= 1'b0;
    end else begin
      if (hreq.we) heat_ok[hreq.addr] <= 1'b1;
      if (cwe) coord_ok[in_ch.led_index] <= 1'b1;
      hrd_ok <= heat_ok[hreq.addr];
      crd_ok <= coord_ok[craddr];
    end
  end
  assign hrd = hrd_ok ? hrd_raw : 8'd0;
  assign crd = crd_ok ? crd_raw : 17'd0;

  state_t      state, state_next;
  logic [6:0]  idx;
  logic [5:0]  led;
  logic [6:0]  count;
  logic [7:0]  px, py;
  logic [7:0]  cur_heat;
  logic [16:0] d2;
  logic [23:0] prod;
  logic [15:0] hprod, bprod;
  logic [15:0] loss;
  logic [7:0]  hue_r, br_r;
  logic        out_pend;
  logic        out_load;

  logic        sq_start, sq_done;
  logic [8:0]  sq_root;
  logic        dv_start, dv_done;
  logic [23:0] dv_num, dv_q;
  logic [15:0] dv_den;

  khle_sqrt u_sqrt (.clk, .rst, .start(sq_start), .value(d2), .done(sq_done), .root(sq_root));
  khle_divider u_div (.clk, .rst, .start(dv_start), .dividend(dv_num), .divisor(dv_den),
                      .done(dv_done), .quotient(dv_q));

  logic [7:0] dx, dy;
  logic [8:0] hsum;
  logic [7:0] contrib;
  logic [7:0] dec;
  logic [6:0] lim;

  assign in_ch.ready = (state == ST_IDLE);
  assign cwe = in_ch.valid && in_ch.ready && in_ch.cmd == CMD_COORD
               && 7'(in_ch.led_index) < CNT;
  assign lim = (in_ch.frame_leds > CNT) ? CNT : in_ch.frame_leds;

  assign dx = (crd[7:0] >= px) ? crd[7:0] - px : px - crd[7:0];
  assign dy = (crd[15:8] >= py) ? crd[15:8] - py : py - crd[15:8];
  // sampled by the square root unit on its start cycle
  assign d2 = 17'(dx) * 17'(dx) + 17'(dy) * 17'(dy);
  assign contrib = (dv_q > 24'(cfg.nb_cap)) ? cfg.nb_cap : dv_q[7:0];
  assign dec = (16'(hrd) <= loss) ? 8'd0 : hrd - loss[7:0];
  assign out_load = (state == ST_FR_OUT) && (!out_pend || out_ch.ready);

  always_comb begin
    state_next = state;
    hreq = '{we: 1'b0, addr: idx[5:0], wdata: 8'd0};
    craddr = idx[5:0];
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_num = prod;
    dv_den = cfg.spread_radius;
    hsum = 9'd0;
    case (state)
      ST_IDLE: begin
        hreq.addr = in_ch.led_index;
        craddr = in_ch.led_index;
        if (in_ch.valid) begin
          case (in_ch.cmd)
            CMD_PRESS: if (7'(in_ch.led_index) < CNT) state_next = ST_PRESS_RD;
            CMD_FRAME: if (lim != 7'd0) begin
              dv_start = 1'b1;
              dv_num = {8'd0, in_ch.elapsed_ms};
              dv_den = (cfg.decay_period_ms == 16'd0) ? 16'd1 : cfg.decay_period_ms;
              state_next = ST_DIV_FR;
            end
            default: ;
          endcase
        end
      end
      ST_PRESS_RD: begin
        hreq.addr = led;
        if (!crd[16]) state_next = ST_IDLE;
        else begin
          hsum = 9'(hrd) + 9'(cfg.press_gain);
          hreq.we = 1'b1;
          hreq.wdata = hsum[8] ? 8'hFF : hsum[7:0];
          state_next = (cfg.slim_mode || cfg.spread_radius == 16'd0) ? ST_IDLE : ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        if (idx == CNT) state_next = ST_IDLE;
        else state_next = ST_NB_WAIT;
      end
      ST_NB_WAIT: begin
        if (!crd[16] || idx[5:0] == led) state_next = ST_NB_RD;
        else begin
          sq_start = 1'b1;
          state_next = ST_NB_SQRT;
        end
      end
      ST_NB_SQRT: if (sq_done) begin
        state_next = (16'(sq_root) > cfg.spread_radius) ? ST_NB_RD : ST_NB_MUL;
      end
      ST_NB_MUL: begin
        dv_start = 1'b1;
        state_next = ST_NB_DIV;
      end
      ST_NB_DIV: if (dv_done) state_next = ST_NB_WR;
      ST_NB_WR: begin
        hsum = 9'(cur_heat) + 9'(contrib);
        hreq.we = 1'b1;
        hreq.wdata = hsum[8] ? 8'hFF : hsum[7:0];
        state_next = ST_NB_RD;
      end
      ST_DIV_FR: if (dv_done) state_next = ST_FR_RD;
      ST_FR_RD: state_next = ST_FR_WAIT;
      ST_FR_WAIT: begin
        hreq.we = 1'b1;
        hreq.wdata = dec;
        state_next = ST_FR_MUL;
      end
      ST_FR_MUL: state_next = ST_FR_OUT;
      ST_FR_OUT: if (out_load) begin
        state_next = (idx + 7'd1 == count) ? ST_IDLE : ST_FR_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_pend <= 1'b0;
      idx      <= '0;
    end else begin
      state <= state_next;
      // hold the result until taken, reload as it leaves
      out_pend <= out_load || (out_pend && !out_ch.ready);
      case (state)
        ST_IDLE: begin
          led   <= in_ch.led_index;
          count <= lim;
          idx   <= '0;
        end
        ST_PRESS_RD: begin
          px <= crd[7:0];
          py <= crd[15:8];
        end
        ST_NB_WAIT: begin
          cur_heat <= hrd;
          if (!crd[16] || idx[5:0] == led) idx <= idx + 7'd1;
        end
        ST_NB_SQRT: if (sq_done) begin
          prod <= 24'(cfg.press_gain) * 24'(cfg.spread_radius - 16'(sq_root));
          if (16'(sq_root) > cfg.spread_radius) idx <= idx + 7'd1;
        end
        ST_NB_WR: idx <= idx + 7'd1;
        ST_DIV_FR: if (dv_done) loss <= (dv_q > 24'd255) ? 16'd255 : dv_q[15:0];
        ST_FR_WAIT: begin
          cur_heat <= dec;
          hprod <= 16'(8'd255 - dec) * 16'd240;
          bprod <= 16'(cfg.base_brightness) * 16'(dec);
        end
        ST_FR_MUL: begin
          hue_r <= div255(hprod);
          br_r  <= div255(bprod);
        end
        ST_FR_OUT: if (out_load) begin
          out_ch.out_led    <= idx[5:0];
          out_ch.heat       <= cur_heat;
          out_ch.hue        <= hue_r;
          out_ch.brightness <= br_r;
          out_ch.lit        <= cur_heat != 8'd0;
          out_ch.last       <= (idx + 7'd1 == count);
          idx <= idx + 7'd1;
        end
        default: ;
      endcase
    end
  end
  assign out_ch.valid = out_pend;

  `ASSERT_IMPL(a_busy_no_ready, clk, rst, state != ST_IDLE, !in_ch.ready, "ready while busy")
  `ASSERT_IMPL(a_lit_heat, clk, rst, out_ch.valid, out_ch.lit == (out_ch.heat != 8'd0), "lit")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid,
               "result dropped")
  `ASSERT_IMPL(a_cold_dark, clk, rst, out_ch.valid && !out_ch.lit, out_ch.brightness == 8'd0,
               "cold LED lit")
endmodule
